FILE: rtl/core/prf_pkg.sv
// Shared types and constants for the Pruefer sequence tree decoder.
// Used by every module in rtl/core; depends on nothing else.
package prf_pkg;

  localparam int SymW     = 4;   // width of a sequence symbol
  localparam int NcW      = 5;   // width of the node count register
  localparam int IdxW     = 7;   // width of the edge index
  localparam int NumSym   = 16;  // symbol values, one occurrence counter each
  localparam int OccW     = 4;   // occurrence counter width, wraps
  localparam int MinNodes = 3;
  localparam int CmdDepth = 2;   // queue between front and back
  localparam int OutDepth = 2;   // result queue

  localparam logic [NcW-1:0] NodeCountReset = 5'd16;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_REBUILD,
    ST_DECODE,
    ST_FINAL
  } prf_state_e;

  // Classification of one accepted symbol.
  typedef struct packed {
    logic done;     // this symbol completes the sequence
    logic rebuild;  // count differs from the sequence length; with done, more symbols stored
  } prf_cmd_ctl_t;

  typedef struct packed {
    logic last;
    logic bad;
  } prf_edge_flags_t;

endpackage

FILE: rtl/core/prufer_sequence_tree_decoder.sv
// Top level of the Pruefer sequence tree decoder: front end, decode back end
// and edge stage. Depends on prf_pkg, prf_front, prf_back and prf_edge.
//
// Usage: write the node count n on the cfg channel (valid/ready, ready is
// always high) while the block is idle; values outside 3..MAX_NODES clamp.
// Push the n-2 sequence symbols one per beat on push/full. A two-entry
// queue lets the next sequence start loading while the back end still
// decodes.
// When the last symbol is accepted the back end walks the sequence once,
// one decode step per cycle unless the edge stage stalls, with a priority
// search over the nodes, and emits an edge per symbol plus a final edge
// marked by last_edge_o. If the node count was lowered mid-load, a recount
// pass over the first n-2 stored symbols comes first. The first edge passes the
// back end state register, the edge stage register and the result queue;
// the edges then follow one per cycle while the reader keeps popping.
// Results wait in a two-entry queue: read with pop while empty is low.
// When the reader stalls, the decoder and then the input queue fill and
// full rises; nothing is dropped.
// Reset empties all queues, clears counters and the used-node mask and sets
// the node count to 16. There is no clearing pass.
module prufer_sequence_tree_decoder #(
  parameter int MAX_NODES = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [prf_pkg::SymW-1:0]    code_symbol_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [prf_pkg::NcW-1:0]     cfg_data_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [prf_pkg::IdxW-1:0]    edge_index_o,
  output logic [prf_pkg::SymW-1:0]    edge_low_node_o,
  output logic [prf_pkg::SymW-1:0]    edge_high_node_o,
  output logic                        last_edge_o,
  output logic                        bad_symbol_o
);
  import prf_pkg::*;

  localparam int SeqDepth = MAX_NODES - 2;
  localparam int AddrW    = (SeqDepth > 1) ? $clog2(SeqDepth) : 1;
  localparam int LW       = ($clog2(MAX_NODES) > SymW) ? $clog2(MAX_NODES) : SymW;

  logic             cmd_valid, cmd_ready;
  logic [SymW-1:0]  cmd_sym;
  logic [AddrW-1:0] cmd_addr;
  logic [NcW-1:0]   cmd_n;
  prf_cmd_ctl_t     cmd_ctl;

  logic             raw_valid, raw_ready;
  logic [LW-1:0]    raw_a, raw_b;
  logic [NcW-1:0]   raw_n;
  prf_edge_flags_t  raw_flags;

  prf_front #(.MAX_NODES(MAX_NODES)) u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .code_symbol_i,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_data_i,
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_sym_o   (cmd_sym),
    .cmd_addr_o  (cmd_addr),
    .cmd_n_o     (cmd_n),
    .cmd_ctl_o   (cmd_ctl)
  );

  prf_back #(.MAX_NODES(MAX_NODES)) u_back (
    .clk_i,
    .rst_ni,
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_sym_i   (cmd_sym),
    .cmd_addr_i  (cmd_addr),
    .cmd_n_i     (cmd_n),
    .cmd_ctl_i   (cmd_ctl),
    .raw_valid_o (raw_valid),
    .raw_ready_i (raw_ready),
    .raw_a_o     (raw_a),
    .raw_b_o     (raw_b),
    .raw_n_o     (raw_n),
    .raw_flags_o (raw_flags)
  );

  prf_edge #(.MAX_NODES(MAX_NODES)) u_edge (
    .clk_i,
    .rst_ni,
    .raw_valid_i (raw_valid),
    .raw_ready_o (raw_ready),
    .raw_a_i     (raw_a),
    .raw_b_i     (raw_b),
    .raw_n_i     (raw_n),
    .raw_flags_i (raw_flags),
    .empty,
    .pop,
    .edge_index_o,
    .edge_low_node_o,
    .edge_high_node_o,
    .last_edge_o,
    .bad_symbol_o
  );

endmodule

FILE: rtl/core/prf_front.sv
// Front end: node count register, symbol acceptance and classification,
// and the command queue toward the decoder. Depends on prf_pkg.
module prf_front #(
  parameter int MAX_NODES = 16,
  localparam int SeqDepth = MAX_NODES - 2,
  localparam int AddrW    = (SeqDepth > 1) ? $clog2(SeqDepth) : 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push,
  output logic                        full,
  input  logic [prf_pkg::SymW-1:0]    code_symbol_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [prf_pkg::NcW-1:0]     cfg_data_i,
  output logic                        cmd_valid_o,
  input  logic                        cmd_ready_i,
  output logic [prf_pkg::SymW-1:0]    cmd_sym_o,
  output logic [AddrW-1:0]            cmd_addr_o,
  output logic [prf_pkg::NcW-1:0]     cmd_n_o,
  output prf_pkg::prf_cmd_ctl_t       cmd_ctl_o
);
  import prf_pkg::*;

  localparam int CntW   = $clog2(SeqDepth + 1);
  localparam int CmpW   = (CntW > NcW) ? CntW : NcW;
  localparam int PtrW   = $clog2(CmdDepth);
  localparam int QcntW  = $clog2(CmdDepth + 1);

  logic [NcW-1:0]   node_count_q;
  logic [NcW-1:0]   n_eff;
  logic [NcW-1:0]   seq_len;
  logic [CntW-1:0]  load_q, load_d, load_next;
  prf_cmd_ctl_t     ctl;
  logic             push_ok, pop_ok;

  logic [SymW-1:0]  q_sym  [CmdDepth];
  logic [AddrW-1:0] q_addr [CmdDepth];
  logic [NcW-1:0]   q_n    [CmdDepth];
  prf_cmd_ctl_t     q_ctl  [CmdDepth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [QcntW-1:0] qcnt_q, qcnt_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NodeCountReset;
    end else if (cfg_valid_i) begin
      node_count_q <= cfg_data_i;
    end
  end

  // Effective node count is the register clamped to the supported range.
  always_comb begin
    n_eff = node_count_q;
    if (int'(node_count_q) < MinNodes) begin
      n_eff = NcW'(MinNodes);
    end else if (int'(node_count_q) > MAX_NODES) begin
      n_eff = NcW'(MAX_NODES);
    end
    seq_len = n_eff - NcW'(2);
  end

  assign full    = (qcnt_q == QcntW'(CmdDepth));
  assign push_ok = push && !full;
  assign pop_ok  = cmd_valid_o && cmd_ready_i;

  always_comb begin
    load_next   = load_q + CntW'(1);
    ctl.done    = (CmpW'(load_next) >= CmpW'(seq_len));
    ctl.rebuild = (CmpW'(load_next) != CmpW'(seq_len));
    load_d      = load_q;
    if (push_ok) begin
      load_d = ctl.done ? '0 : load_next;
    end
  end

  always_comb begin
    qcnt_d = qcnt_q;
    if (push_ok && !pop_ok) begin
      qcnt_d = qcnt_q + QcntW'(1);
    end else if (!push_ok && pop_ok) begin
      qcnt_d = qcnt_q - QcntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
      qcnt_q <= '0;
      wr_q   <= '0;
      rd_q   <= '0;
    end else begin
      load_q <= load_d;
      qcnt_q <= qcnt_d;
      if (push_ok) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (pop_ok) begin
        rd_q <= rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      q_sym[wr_q]  <= code_symbol_i;
      q_addr[wr_q] <= load_q[AddrW-1:0];
      q_n[wr_q]    <= n_eff;
      q_ctl[wr_q]  <= ctl;
    end
  end

  assign cmd_valid_o = (qcnt_q != '0);
  assign cmd_sym_o   = q_sym[rd_q];
  assign cmd_addr_o  = q_addr[rd_q];
  assign cmd_n_o     = q_n[rd_q];
  assign cmd_ctl_o   = q_ctl[rd_q];

`ifndef SYNTHESIS
  // The load position never reaches the store depth: a full store always ends a sequence.
  a_load_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(load_q) < SeqDepth)
    else $error("load position beyond sequence store");
`endif

endmodule

FILE: rtl/core/prf_back.sv
// Back end: sequence store, occurrence counters and the decode sequencer
// that produces one raw edge per step. Depends on prf_pkg.
module prf_back #(
  parameter int MAX_NODES = 16,
  localparam int SeqDepth = MAX_NODES - 2,
  localparam int AddrW    = (SeqDepth > 1) ? $clog2(SeqDepth) : 1,
  localparam int LW       = ($clog2(MAX_NODES) > prf_pkg::SymW) ?
                            $clog2(MAX_NODES) : prf_pkg::SymW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  output logic                        cmd_ready_o,
  input  logic [prf_pkg::SymW-1:0]    cmd_sym_i,
  input  logic [AddrW-1:0]            cmd_addr_i,
  input  logic [prf_pkg::NcW-1:0]     cmd_n_i,
  input  prf_pkg::prf_cmd_ctl_t       cmd_ctl_i,
  output logic                        raw_valid_o,
  input  logic                        raw_ready_i,
  output logic [LW-1:0]               raw_a_o,
  output logic [LW-1:0]               raw_b_o,
  output logic [prf_pkg::NcW-1:0]     raw_n_o,
  output prf_pkg::prf_edge_flags_t    raw_flags_o
);
  import prf_pkg::*;

  localparam int CmpW = (AddrW > NcW) ? AddrW : NcW;

  prf_state_e      state_q, state_d;
  logic [SymW-1:0] store_q [SeqDepth];
  logic [OccW-1:0] count_q [NumSym];
  logic [NumSym-1:0]    seen_q;
  logic [MAX_NODES-1:0] used_q;
  logic [NcW-1:0]  n_q, len_q;
  logic [AddrW-1:0] step_q;

  logic [SymW-1:0]      cur_sym;
  logic                 step_last;
  logic                 load_pop, load_done;
  logic [NumSym-1:0]    cnt_zero, below_n;
  logic [MAX_NODES-1:0] free_v, free_oh, unused_v, first_oh, rest_v, second_oh;
  logic [MAX_NODES-1:0] mark_oh;
  logic [LW-1:0]        pick, node_a, node_b;
  logic                 bad;

  assign cur_sym   = store_q[step_q];
  assign step_last = (CmpW'(step_q) == CmpW'(len_q) - CmpW'(1));
  assign load_pop  = (state_q == ST_LOAD) && cmd_valid_i;
  assign load_done = load_pop && cmd_ctl_i.done;

  // Node v is free when unused, inside the tree and absent from the rest of the sequence.
  always_comb begin
    for (int s = 0; s < NumSym; s++) begin
      cnt_zero[s] = (count_q[s] == '0);
      below_n[s]  = (s < int'(n_q));
    end
    for (int v = 0; v < MAX_NODES; v++) begin
      unused_v[v] = !used_q[v] && (v < int'(n_q));
      free_v[v]   = unused_v[v] && ((v < NumSym) ? cnt_zero[v % NumSym] : 1'b1);
    end
    free_oh   = free_v & (~free_v + MAX_NODES'(1));
    first_oh  = unused_v & (~unused_v + MAX_NODES'(1));
    rest_v    = unused_v & ~first_oh;
    second_oh = rest_v & (~rest_v + MAX_NODES'(1));
    // With no free node the pick falls back to node zero, which is then marked used.
    mark_oh   = (free_v == '0) ? MAX_NODES'(1) : free_oh;
    pick   = '0;
    node_a = '0;
    node_b = '0;
    for (int v = 0; v < MAX_NODES; v++) begin
      if (free_oh[v])   pick   = pick   | LW'(v);
      if (first_oh[v])  node_a = node_a | LW'(v);
      if (second_oh[v]) node_b = node_b | LW'(v);
    end
    bad = |(seen_q & ~below_n);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (load_done) begin
          state_d = cmd_ctl_i.rebuild ? ST_REBUILD : ST_DECODE;
        end
      end
      ST_REBUILD: begin
        if (step_last) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        if (raw_ready_i && step_last) state_d = ST_FINAL;
      end
      ST_FINAL: begin
        if (raw_ready_i) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    cmd_ready_o      = 1'b0;
    raw_valid_o      = 1'b0;
    raw_a_o          = pick;
    raw_b_o          = LW'(cur_sym);
    raw_flags_o.last = 1'b0;
    raw_flags_o.bad  = bad;
    case (state_q)
      ST_LOAD:    cmd_ready_o = 1'b1;
      ST_REBUILD: ;
      ST_DECODE:  raw_valid_o = 1'b1;
      ST_FINAL: begin
        raw_valid_o      = 1'b1;
        raw_a_o          = node_a;
        raw_b_o          = node_b;
        raw_flags_o.last = 1'b1;
      end
      default: ;
    endcase
  end
  assign raw_n_o = n_q;

  always_ff @(posedge clk_i) begin
    if (load_pop) begin
      store_q[cmd_addr_i] <= cmd_sym_i;
    end
    if (load_done) begin
      n_q   <= cmd_n_i;
      len_q <= cmd_n_i - NcW'(2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      step_q  <= '0;
      seen_q  <= '0;
      used_q  <= '0;
      for (int s = 0; s < NumSym; s++) count_q[s] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_LOAD: begin
          if (load_pop) begin
            if (cmd_ctl_i.done && cmd_ctl_i.rebuild) begin
              // Extra symbols were stored: recount over the decoded part only.
              seen_q <= '0;
              for (int s = 0; s < NumSym; s++) count_q[s] <= '0;
            end else begin
              count_q[cmd_sym_i] <= count_q[cmd_sym_i] + OccW'(1);
              seen_q[cmd_sym_i]  <= 1'b1;
            end
            step_q <= '0;
          end
        end
        ST_REBUILD: begin
          count_q[cur_sym] <= count_q[cur_sym] + OccW'(1);
          seen_q[cur_sym]  <= 1'b1;
          step_q <= step_last ? '0 : step_q + AddrW'(1);
        end
        ST_DECODE: begin
          if (raw_ready_i) begin
            if (count_q[cur_sym] != '0) begin
              count_q[cur_sym] <= count_q[cur_sym] - OccW'(1);
            end
            used_q <= used_q | mark_oh;
            step_q <= step_q + AddrW'(1);
          end
        end
        ST_FINAL: begin
          if (raw_ready_i) begin
            used_q <= '0;
            seen_q <= '0;
            for (int s = 0; s < NumSym; s++) count_q[s] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_step_in_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DECODE || state_q == ST_REBUILD) |-> CmpW'(step_q) < CmpW'(len_q))
    else $error("decode step beyond sequence length");
  a_clear_after_tree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL && raw_ready_i) |=> (used_q == '0 && seen_q == '0))
    else $error("tree state not cleared after final edge");
`endif

endmodule

FILE: rtl/core/prf_edge.sv
// Edge stage: turns a raw node pair into an ordered edge with its
// lexicographic index and queues results for the reader. Depends on prf_pkg.
module prf_edge #(
  parameter int MAX_NODES = 16,
  localparam int LW       = ($clog2(MAX_NODES) > prf_pkg::SymW) ?
                            $clog2(MAX_NODES) : prf_pkg::SymW
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        raw_valid_i,
  output logic                        raw_ready_o,
  input  logic [LW-1:0]               raw_a_i,
  input  logic [LW-1:0]               raw_b_i,
  input  logic [prf_pkg::NcW-1:0]     raw_n_i,
  input  prf_pkg::prf_edge_flags_t    raw_flags_i,
  output logic                        empty,
  input  logic                        pop,
  output logic [prf_pkg::IdxW-1:0]    edge_index_o,
  output logic [prf_pkg::SymW-1:0]    edge_low_node_o,
  output logic [prf_pkg::SymW-1:0]    edge_high_node_o,
  output logic                        last_edge_o,
  output logic                        bad_symbol_o
);
  import prf_pkg::*;

  localparam int PW    = 2 * LW + 2;
  localparam int PtrW  = $clog2(OutDepth);
  localparam int QcntW = $clog2(OutDepth + 1);

  logic                 stg_v_q;
  logic [LW-1:0]        stg_a_q, stg_b_q;
  logic [NcW-1:0]       stg_n_q;
  prf_edge_flags_t      stg_f_q;

  logic [LW-1:0]        lo, hi;
  logic [PW-1:0]        lo_e, hi_e, prod_ln, prod_tri, sum;
  logic                 room, move, take;

  logic [IdxW-1:0]      q_idx  [OutDepth];
  logic [SymW-1:0]      q_lo   [OutDepth];
  logic [SymW-1:0]      q_hi   [OutDepth];
  prf_edge_flags_t      q_f    [OutDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [QcntW-1:0]     qcnt_q, qcnt_d;

  // Index of (lo,hi) is lo*n - lo*(lo+1)/2 + hi - lo - 1, kept modulo 128.
  always_comb begin
    lo       = (stg_a_q < stg_b_q) ? stg_a_q : stg_b_q;
    hi       = (stg_a_q < stg_b_q) ? stg_b_q : stg_a_q;
    lo_e     = PW'(lo);
    hi_e     = PW'(hi);
    prod_ln  = lo_e * PW'(stg_n_q);
    prod_tri = lo_e * (lo_e + PW'(1));
    sum      = prod_ln - (prod_tri >> 1) + hi_e - lo_e - PW'(1);
  end

  assign room        = (qcnt_q != QcntW'(OutDepth));
  assign move        = stg_v_q && room;
  assign raw_ready_o = !stg_v_q || room;
  assign take        = pop && !empty;

  always_comb begin
    qcnt_d = qcnt_q;
    if (move && !take) begin
      qcnt_d = qcnt_q + QcntW'(1);
    end else if (!move && take) begin
      qcnt_d = qcnt_q - QcntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_v_q <= 1'b0;
      qcnt_q  <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
    end else begin
      if (raw_ready_o) begin
        stg_v_q <= raw_valid_i;
      end
      qcnt_q <= qcnt_d;
      if (move) begin
        wr_q <= wr_q + PtrW'(1);
      end
      if (take) begin
        rd_q <= rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (raw_ready_o && raw_valid_i) begin
      stg_a_q <= raw_a_i;
      stg_b_q <= raw_b_i;
      stg_n_q <= raw_n_i;
      stg_f_q <= raw_flags_i;
    end
    if (move) begin
      q_idx[wr_q] <= sum[IdxW-1:0];
      q_lo[wr_q]  <= lo[SymW-1:0];
      q_hi[wr_q]  <= hi[SymW-1:0];
      q_f[wr_q]   <= stg_f_q;
    end
  end

  assign empty            = (qcnt_q == '0);
  assign edge_index_o     = q_idx[rd_q];
  assign edge_low_node_o  = q_lo[rd_q];
  assign edge_high_node_o = q_hi[rd_q];
  assign last_edge_o      = q_f[rd_q].last;
  assign bad_symbol_o     = q_f[rd_q].bad;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(qcnt_q) <= OutDepth)
    else $error("result queue overfilled");
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stg_v_q && !room) |=> (stg_v_q && $stable(stg_a_q) && $stable(stg_b_q)))
    else $error("stalled edge stage lost its beat");
`endif

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for prufer_sequence_tree_decoder: queued symbol driver,
// edge monitor and an in-bench tree decoder that predicts every edge beat.
// Depends on prf_pkg and the decoder RTL only.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import prf_pkg::*;

  localparam int MaxNodes = 16;
  localparam int SeqDepth = MaxNodes - 2;
  localparam int SettleCycles = 40;

  typedef struct packed {
    logic [IdxW-1:0] idx;
    logic [SymW-1:0] low_node;
    logic [SymW-1:0] high_node;
    logic            last;
    logic            bad;
  } tree_edge_t;

  logic            clk_i;
  logic            rst_ni = 1'b0;
  logic            push = 1'b0;
  logic            full;
  logic [SymW-1:0] code_symbol_i = '0;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [NcW-1:0]  cfg_data_i = '0;
  logic            empty;
  logic            pop = 1'b0;
  logic [IdxW-1:0] edge_index_o;
  logic [SymW-1:0] edge_low_node_o;
  logic [SymW-1:0] edge_high_node_o;
  logic            last_edge_o;
  logic            bad_symbol_o;

  prufer_sequence_tree_decoder #(
    .MAX_NODES(MaxNodes)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .code_symbol_i   (code_symbol_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .empty           (empty),
    .pop             (pop),
    .edge_index_o    (edge_index_o),
    .edge_low_node_o (edge_low_node_o),
    .edge_high_node_o(edge_high_node_o),
    .last_edge_o     (last_edge_o),
    .bad_symbol_o    (bad_symbol_o)
  );

  // Stimulus and prediction state.
  logic [SymW-1:0] symbol_q[$];
  tree_edge_t      edge_q[$];
  logic [SymW-1:0] seq_mem[SeqDepth];
  int              fill_cnt = 0;
  logic [NcW-1:0]  node_cfg = NodeCountReset;
  int              mismatches = 0;
  bit              no_idle = 1'b0;
  int              gap_left = 0;
  int              stall_left = 0;
  tree_edge_t      got_edge;
  tree_edge_t      want_edge;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int tree_nodes(logic [NcW-1:0] cfg);
    if (cfg < MinNodes) return MinNodes;
    if (cfg > MaxNodes) return MaxNodes;
    return int'(cfg);
  endfunction

  // Mostly short gaps, now and then a long one; none at all in quiet phases.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_edge(int a, int b, int n, bit last, bit bad);
    tree_edge_t e;
    int lo;
    int hi;
    int idx;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    idx = lo * n - (lo * (lo + 1)) / 2 + (hi - lo - 1);
    e.idx       = idx[IdxW-1:0];
    e.low_node  = lo[SymW-1:0];
    e.high_node = hi[SymW-1:0];
    e.last      = last;
    e.bad       = bad;
    edge_q.push_back(e);
  endfunction

  // Rebuilds the occurrence counts from the first n-2 stored symbols, then
  // repeatedly joins the smallest free leaf to the next symbol, then the last two.
  function automatic void walk_sequence(int n);
    logic [OccW-1:0] occ[NumSym];
    logic [15:0]     used;
    logic [SymW-1:0] s;
    bit              bad;
    int              pick;
    int              a;
    int              b;
    used = '0;
    bad = 1'b0;
    foreach (occ[v]) occ[v] = '0;
    for (int i = 0; i < n - 2; i++) begin
      s = seq_mem[i];
      occ[s] = occ[s] + 1'b1;
      if (int'(s) >= n) bad = 1'b1;
    end
    for (int i = 0; i < n - 2; i++) begin
      s = seq_mem[i];
      pick = 0;
      for (int v = n - 1; v >= 0; v--) begin
        if (!used[v] && occ[v] == 0) pick = v;
      end
      add_edge(pick, int'(s), n, 1'b0, bad);
      if (occ[s] != 0) occ[s] = occ[s] - 1'b1;
      used[pick] = 1'b1;
    end
    a = -1;
    b = -1;
    for (int v = 0; v < n; v++) begin
      if (!used[v]) begin
        if (a < 0) a = v;
        else if (b < 0) b = v;
      end
    end
    add_edge(a, b, n, 1'b1, bad);
    fill_cnt = 0;
  endfunction

  function automatic void load_symbol(logic [SymW-1:0] sym);
    int n;
    n = tree_nodes(node_cfg);
    if (fill_cnt < SeqDepth) begin
      seq_mem[fill_cnt] = sym;
      fill_cnt++;
    end
    if (fill_cnt >= n - 2) walk_sequence(n);
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  // Symbol driver; also tracks writes to the node count register.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) node_cfg = cfg_data_i;
      if (push && !full) begin
        load_symbol(code_symbol_i);
        gap_left = idle_len();
      end
      if (!(push && full)) begin
        if (gap_left > 0) begin
          push <= 1'b0;
          gap_left--;
        end else if (symbol_q.size() != 0) begin
          push <= 1'b1;
          code_symbol_i <= symbol_q.pop_front();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // Edge monitor: every popped beat is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        got_edge = '{edge_index_o, edge_low_node_o, edge_high_node_o, last_edge_o,
                     bad_symbol_o};
        if (edge_q.size() == 0) begin
          $display("%0t: edge beat with none expected, expected nothing, got %p",
                   $time, got_edge);
          mismatches++;
        end else begin
          want_edge = edge_q.pop_front();
          check_field("edge_index", want_edge.idx, got_edge.idx);
          check_field("edge_low_node", want_edge.low_node, got_edge.low_node);
          check_field("edge_high_node", want_edge.high_node, got_edge.high_node);
          check_field("last_edge", want_edge.last, got_edge.last);
          check_field("bad_symbol", want_edge.bad, got_edge.bad);
        end
      end
      if (stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    while (!(symbol_q.size() == 0 && !push && edge_q.size() == 0)) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_node_count(logic [NcW-1:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One full sequence; noisy ones draw symbols from the whole 4-bit range.
  task automatic queue_sequence(int n, bit noisy, inout int cnt);
    for (int i = 0; i < n - 2; i++) begin
      symbol_q.push_back(noisy ? SymW'($urandom_range(0, 15))
                               : SymW'($urandom_range(0, n - 1)));
      cnt++;
    end
  endtask

  initial begin
    logic [SymW-1:0] first_tree[$];
    logic [SymW-1:0] partial[$];
    logic [NcW-1:0]  nc;
    int              n;
    int              random_items;
    int              r;

    first_tree = '{0, 15, 15, 0, 7, 8, 1, 14, 2, 13, 3, 12, 4, 11};
    partial = '{3, 3, 9, 15, 0};
    random_items = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: full-length tree at the reset node count.
    foreach (first_tree[i]) symbol_q.push_back(first_tree[i]);
    // Smallest trees, one symbol each, including a symbol out of range.
    write_node_count(5'd3);
    symbol_q.push_back(4'd0);
    symbol_q.push_back(4'd2);
    symbol_q.push_back(4'd15);
    // Node counts below and above the legal range clamp.
    write_node_count(5'd0);
    symbol_q.push_back(4'd1);
    write_node_count(5'd31);
    foreach (partial[i]) symbol_q.push_back(partial[i]);
    // Lowering the node count mid-load decodes the first n-2 stored symbols.
    write_node_count(5'd5);
    symbol_q.push_back(4'd4);

    while (random_items < 140) begin
      no_idle = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r == 0) nc = NcW'($urandom_range(0, 2));
      else if (r == 1) nc = NcW'($urandom_range(17, 31));
      else nc = NcW'($urandom_range(3, 16));
      write_node_count(nc);
      n = tree_nodes(nc);
      repeat ($urandom_range(1, 4)) begin
        queue_sequence(n, $urandom_range(0, 4) == 0, random_items);
      end
      // Sometimes leave a sequence half loaded for the next setting to pick up.
      if (n > 3 && $urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, n - 3)) begin
          symbol_q.push_back(SymW'($urandom_range(0, 15)));
          random_items++;
        end
      end
    end
    no_idle = 1'b0;

    wait_idle();
    if (mismatches == 0 && edge_q.size() == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
